// ----- hw/rtl/angsec_pkg.sv -----
// Shared types and constants for the angle sector selector.
// Holds the CORDIC datapath record and the arctangent table; no dependencies.
package angsec_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = DIFF_W + 1;
  localparam int PRE_SCALE = 24;
  localparam int XY_W      = 44;
  localparam int ACC_W     = 32;
  localparam int ANG_W     = 16;
  localparam int SECT_W    = 6;
  localparam int TABLE_LEN = 24;

  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [ACC_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
  } cordic_t;

endpackage

// ----- hw/rtl/angsec_prep.sv -----
// Front end: difference vector, then left half-plane fold and pre-scaling.
// Two register stages; depends on angsec_pkg.
module angsec_prep
  import angsec_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [COORD_W-1:0] mobile_x,
  input  logic signed [COORD_W-1:0] mobile_y,
  input  logic signed [COORD_W-1:0] station_x,
  input  logic signed [COORD_W-1:0] station_y,
  output cordic_t                   q
);

  logic                     vld_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic signed [MAG_W-1:0]  ax, ay;
  cordic_t                  q_r, q_nxt;

  assign dx_nxt = DIFF_W'(mobile_x) - DIFF_W'(station_x);
  assign dy_nxt = DIFF_W'(mobile_y) - DIFF_W'(station_y);

  always_comb begin
    q_nxt.vld  = vld_r;
    q_nxt.zero = (dx_r == '0) && (dy_r == '0);
    if (dx_r[DIFF_W-1]) begin
      ax        = -MAG_W'(dx_r);
      ay        = -MAG_W'(dy_r);
      q_nxt.acc = HALF_TURN;
    end else begin
      ax        = MAG_W'(dx_r);
      ay        = MAG_W'(dy_r);
      q_nxt.acc = '0;
    end
    q_nxt.x = {{(XY_W-MAG_W-PRE_SCALE){ax[MAG_W-1]}}, ax, {PRE_SCALE{1'b0}}};
    q_nxt.y = {{(XY_W-MAG_W-PRE_SCALE){ay[MAG_W-1]}}, ay, {PRE_SCALE{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // Only the valid bit is cleared by reset; the data fields simply follow it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- hw/rtl/angsec_cordic_stage.sv -----
// One registered CORDIC vectoring iteration with a fixed shift.
// Depends on angsec_pkg for the record type and arctangent table.
module angsec_cordic_stage
  import angsec_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cordic_t d,
  output cordic_t q
);

  logic signed [XY_W-1:0] xs, ys;
  logic                   y_pos;
  cordic_t                q_r, q_nxt;

  assign xs    = d.x >>> IDX;
  assign ys    = d.y >>> IDX;
  assign y_pos = !d.y[XY_W-1] && (d.y != '0);

  always_comb begin
    q_nxt      = d;
    if (y_pos) begin
      q_nxt.x   = d.x + ys;
      q_nxt.y   = d.y - xs;
      q_nxt.acc = d.acc + ATAN_TURNS[IDX];
    end else begin
      q_nxt.x   = d.x - ys;
      q_nxt.y   = d.y + xs;
      q_nxt.acc = d.acc - ATAN_TURNS[IDX];
    end
  end

  // Only the valid bit is cleared by reset; the data fields simply follow it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- hw/rtl/angsec_quant.sv -----
// Back end: rounds the turn accumulator to 16 bits, then maps it to a sector.
// Two register stages; depends on angsec_pkg.
module angsec_quant
  import angsec_pkg::*;
#(
  parameter int NUM_SECTORS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cordic_t           d,
  output logic              q_vld,
  output logic [SECT_W-1:0] q_sector
);

  localparam int NS_W = SECT_W + 1;
  localparam int PROD_W = ANG_W + NS_W;
  localparam logic [NS_W-1:0] NSEC = NS_W'(NUM_SECTORS);

  logic                vld1_r, vld2_r;
  logic [ANG_W-1:0]    ang_r, ang_nxt;
  logic [ACC_W-1:0]    acc_rnd;
  logic [PROD_W-1:0]   prod, prod_rnd;
  logic [NS_W-1:0]     sect_raw, sect_wrap;
  logic [SECT_W-1:0]   sector_r;

  assign acc_rnd = d.acc + ACC_W'(32'h0000_8000);
  assign ang_nxt = d.zero ? '0 : acc_rnd[ACC_W-1 -: ANG_W];

  assign prod      = {{NS_W{1'b0}}, ang_r} * {{ANG_W{1'b0}}, NSEC};
  assign prod_rnd  = prod + PROD_W'(32'h0000_8000);
  assign sect_raw  = prod_rnd[PROD_W-1 -: NS_W];
  assign sect_wrap = (sect_raw >= NSEC) ? sect_raw - NSEC : sect_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= d.vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r    <= ang_nxt;
      sector_r <= sect_wrap[SECT_W-1:0];
    end
  end

  assign q_vld    = vld2_r;
  assign q_sector = sector_r;

endmodule

// ----- hw/rtl/angle_sector_select_core.sv -----
// Throughput: one request per cycle unless the output stalls; every stage holds one item
// and the whole pipe advances together, so the rate is set by the registered CORDIC stages.
// Reset: synchronous, active low; clears all valid bits, so the pipe comes up empty.
// Depends on angsec_pkg, angsec_prep, angsec_cordic_stage and angsec_quant.
module angle_sector_select_core
  import angsec_pkg::*;
#(
  parameter int NUM_SECTORS   = 3,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mobile_x [15:0], mobile_y [31:16], station_x [47:32], station_y [63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sector_index [5:0], zeros [7:6]
  output logic [7:0]  out_tdata
);

  // The table has 24 entries, so no more iterations than that are run.
  localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  logic              en;
  logic              q_vld;
  logic [SECT_W-1:0] q_sector;
  cordic_t           stg [NSTG+1];

  // The pipe moves as one whenever the result register is empty or being taken.
  // A stall therefore freezes every stage in place and nothing is dropped or duplicated.
  assign en        = !q_vld || out_tready;
  assign in_tready = en;

  angsec_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid),
    .mobile_x  (in_tdata[15:0]),
    .mobile_y  (in_tdata[31:16]),
    .station_x (in_tdata[47:32]),
    .station_y (in_tdata[63:48]),
    .q         (stg[0])
  );

  // One registered iteration per stage; the shift and table entry are fixed per stage.
  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    angsec_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (stg[i]),
      .q     (stg[i+1])
    );
  end

  // Rounding to the 16-bit angle and the sector mapping; equal positions give sector 0.
  angsec_quant #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d        (stg[NSTG]),
    .q_vld    (q_vld),
    .q_sector (q_sector)
  );

  assign out_tvalid = q_vld;
  assign out_tdata  = {2'b00, q_sector};

endmodule

// ----- hw/rtl/angsec_checker.sv -----
// Port-level checks for the angle sector selector, bound to the top level.
// Depends only on the top level's ports.
module angsec_checker #(
  parameter int NUM_SECTORS = 3
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  localparam logic [7:0] NSEC = 8'(NUM_SECTORS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata < NSEC)
    else $error("sector index out of range");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not track the output side");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while the result is stalled");

endmodule

bind angle_sector_select_core angsec_checker #(
  .NUM_SECTORS (NUM_SECTORS)
) u_angsec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
